### hdl/fmb_pkg.sv
// Shared types, constants and helper functions for the Fock matrix element build unit.
// No dependencies.
package fmb_pkg;

  localparam int MAX_DOF   = 64;
  localparam int DOF_W     = $clog2(MAX_DOF);
  localparam int ADDR_W    = 2 * DOF_W;
  localparam int FRAC_BITS = 20;
  localparam int VAL_W     = 32;
  localparam int PROD_W    = 44;
  localparam int ACC_W     = 64;

  localparam logic [1:0] KIND_LOAD_H = 2'd0;
  localparam logic [1:0] KIND_LOAD_V = 2'd1;
  localparam logic [1:0] KIND_LOAD_D = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic [1:0] CFG_ATOM_COUNT = 2'd0;
  localparam logic [1:0] CFG_ORBITALS   = 2'd1;
  localparam logic [1:0] CFG_DIPOLE     = 2'd2;

  localparam logic signed [VAL_W-1:0] Q_ONE = 32'sh0010_0000;

  typedef struct packed {
    logic [ADDR_W-1:0] h_addr;
    logic [ADDR_W-1:0] v_addr;
    logic [ADDR_W-1:0] d_addr;
  } rd_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (x > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[VAL_W-1:0];
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] chi(input logic [1:0] a, input logic [1:0] b,
                                                  input logic [1:0] c,
                                                  input logic signed [VAL_W-1:0] dip);
    if (a == b && c == 2'd0) begin
      chi = Q_ONE;
    end else if (a == c && c != 2'd0 && b == 2'd0) begin
      chi = dip;
    end else if (b == c && c != 2'd0 && a == 2'd0) begin
      chi = dip;
    end else begin
      chi = '0;
    end
  endfunction

  // quotient of an orbital index by the orbital count (1 to 4)
  function automatic logic [DOF_W-1:0] div_n(input logic [DOF_W-1:0] p, input logic [2:0] n);
    logic [DOF_W+6:0] m;
    m = {7'd0, p} * (DOF_W+7)'(43);
    case (n)
      3'd1:    div_n = p;
      3'd2:    div_n = p >> 1;
      3'd3:    div_n = m[DOF_W+6:7];
      default: div_n = p >> 2;
    endcase
  endfunction

  function automatic logic [DOF_W-1:0] orb_idx(input logic [DOF_W-1:0] atom, input logic [2:0] n,
                                               input logic [1:0] orb);
    logic [DOF_W+2:0] m;
    m = {3'd0, atom} * {{DOF_W{1'b0}}, n};
    orb_idx = m[DOF_W-1:0] + {{(DOF_W-2){1'b0}}, orb};
  endfunction

endpackage

### hdl/fmb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fmb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/fmb_mul.sv
// Shared signed Q11.20 multiplier: full product, floor shift, registered result.
// Depends on fmb_pkg.
module fmb_mul (
  input  logic                                clk,
  input  logic signed [fmb_pkg::VAL_W-1:0]    mul_a,
  input  logic signed [fmb_pkg::VAL_W-1:0]    mul_b,
  output logic signed [fmb_pkg::PROD_W-1:0]   prod_r
);
  import fmb_pkg::*;

  logic signed [2*VAL_W-1:0] full;
  logic signed [2*VAL_W-1:0] shifted;

  assign full    = mul_a * mul_b;
  assign shifted = full >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    prod_r <= shifted[PROD_W-1:0];
  end

endmodule

### hdl/fmb_ctrl.sv
// Sequencer for one Fock element read: index walk, operand select, accumulator, result register.
// Depends on fmb_pkg; drives the shared multiplier fmb_mul and the store read ports.
module fmb_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [fmb_pkg::DOF_W-1:0]           in_row,
  input  logic [fmb_pkg::DOF_W-1:0]           in_col,
  input  logic [2:0]                          orbitals,
  input  logic [6:0]                          atom_count,
  input  logic signed [fmb_pkg::VAL_W-1:0]    dipole,
  input  logic signed [fmb_pkg::VAL_W-1:0]    h_rdata,
  input  logic signed [fmb_pkg::VAL_W-1:0]    v_rdata,
  input  logic signed [fmb_pkg::VAL_W-1:0]    d_rdata,
  input  logic signed [fmb_pkg::PROD_W-1:0]   prod,
  input  logic                                out_stall,
  output logic                                busy,
  output fmb_pkg::rd_t                        rd,
  output logic signed [fmb_pkg::VAL_W-1:0]    mul_a,
  output logic signed [fmb_pkg::VAL_W-1:0]    mul_b,
  output logic                                out_valid,
  output logic [fmb_pkg::DOF_W-1:0]           out_row,
  output logic [fmb_pkg::DOF_W-1:0]           out_col,
  output logic signed [fmb_pkg::VAL_W-1:0]    out_value
);
  import fmb_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_HLD   = 3'd2;
  localparam logic [2:0] ST_ADDR  = 3'd3;
  localparam logic [2:0] ST_CC    = 3'd4;
  localparam logic [2:0] ST_VD    = 3'd5;
  localparam logic [2:0] ST_TERM  = 3'd6;
  localparam logic [2:0] ST_ACC   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       done_r, done_nxt;

  logic [DOF_W-1:0] p_r, p_nxt, q_r, q_nxt;
  logic [2:0]       n_r, n_nxt;
  logic [6:0]       atoms_r, atoms_nxt;
  logic [DOF_W-1:0] ap_r, ap_nxt, aq_r, aq_nxt;
  logic [1:0]       op_r, op_nxt, oq_r, oq_nxt;
  logic             ok_r, ok_nxt;
  logic             phase_r, phase_nxt;
  logic [1:0]       i0_r, i0_nxt, i1_r, i1_nxt, i2_r, i2_nxt, i3_r, i3_nxt;
  logic [DOF_W-1:0] ar_r, ar_nxt;
  logic signed [VAL_W-1:0] c1_r, c1_nxt, c2_r, c2_nxt, cc_r, cc_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    ov_r, ov_nxt;
  logic [DOF_W-1:0]        orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic signed [VAL_W-1:0] oval_r, oval_nxt;

  logic [2:0]       n_eff;
  logic [6:0]       amax;
  logic [9:0]       ndof_full;
  logic [6:0]       ndof;
  logic [DOF_W-1:0] ap_c, aq_c;
  logic [DOF_W+2:0] apn, aqn;
  logic [1:0]       nm1;
  logic [DOF_W-1:0] atm1;
  logic             w3, w2, w1, wa, w0;
  logic signed [ACC_W-1:0] term64;
  logic signed [VAL_W-1:0] prod_sat;

  assign busy      = (state_r != ST_IDLE) || done_r;
  assign out_valid = ov_r;
  assign out_row   = orow_r;
  assign out_col   = ocol_r;
  assign out_value = oval_r;

  assign nm1      = 2'(n_r - 3'd1);
  assign atm1     = 6'(atoms_r - 7'd1);
  assign prod_sat = sat32({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});
  assign term64   = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_comb begin
    if (orbitals == 3'd0) begin
      n_eff = 3'd1;
    end else if (orbitals > 3'd4) begin
      n_eff = 3'd4;
    end else begin
      n_eff = orbitals;
    end
    case (n_eff)
      3'd1:    amax = 7'd64;
      3'd2:    amax = 7'd32;
      3'd3:    amax = 7'd21;
      default: amax = 7'd16;
    endcase
  end

  assign ndof_full = atoms_r * n_r;
  assign ndof      = ndof_full[6:0];
  assign ap_c      = div_n(p_r, n_r);
  assign aq_c      = div_n(q_r, n_r);
  assign apn       = {3'd0, ap_c} * {{DOF_W{1'b0}}, n_r};
  assign aqn       = {3'd0, aq_c} * {{DOF_W{1'b0}}, n_r};

  always_comb begin
    rd.h_addr = {p_r, q_r};
    if (!phase_r) begin
      rd.v_addr = {orb_idx(ap_r, n_r, i0_r), orb_idx(ar_r, n_r, i3_r)};
      rd.d_addr = {orb_idx(ar_r, n_r, i1_r), orb_idx(ar_r, n_r, i2_r)};
    end else begin
      rd.v_addr = {orb_idx(aq_r, n_r, i3_r), orb_idx(ap_r, n_r, i1_r)};
      rd.d_addr = {orb_idx(aq_r, n_r, i2_r), orb_idx(ap_r, n_r, i0_r)};
    end
  end

  always_comb begin
    case (state_r)
      ST_CC: begin
        mul_a = c1_r;
        mul_b = c2_r;
      end
      ST_VD: begin
        mul_a = v_rdata;
        mul_b = d_rdata;
      end
      default: begin
        mul_a = cc_r;
        mul_b = prod_sat;
      end
    endcase
  end

  assign w3 = (i3_r == nm1);
  assign w2 = w3 && (i2_r == nm1);
  assign w1 = w2 && (i1_r == nm1);
  assign wa = w1 && (phase_r || ar_r == atm1);
  assign w0 = wa && (i0_r == nm1);

  always_comb begin
    state_nxt = state_r;
    done_nxt  = done_r;
    p_nxt = p_r;  q_nxt = q_r;  n_nxt = n_r;  atoms_nxt = atoms_r;
    ap_nxt = ap_r;  aq_nxt = aq_r;  op_nxt = op_r;  oq_nxt = oq_r;
    ok_nxt = ok_r;  phase_nxt = phase_r;
    i0_nxt = i0_r;  i1_nxt = i1_r;  i2_nxt = i2_r;  i3_nxt = i3_r;  ar_nxt = ar_r;
    c1_nxt = c1_r;  c2_nxt = c2_r;  cc_nxt = cc_r;  acc_nxt = acc_r;
    ov_nxt = ov_r;  orow_nxt = orow_r;  ocol_nxt = ocol_r;  oval_nxt = oval_r;

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    if (done_r) begin
      if (!ov_r || !out_stall) begin
        ov_nxt   = 1'b1;
        orow_nxt = p_r;
        ocol_nxt = q_r;
        oval_nxt = sat32(acc_r);
        done_nxt = 1'b0;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            p_nxt     = in_row;
            q_nxt     = in_col;
            n_nxt     = n_eff;
            atoms_nxt = (atom_count > amax) ? amax : atom_count;
            state_nxt = ST_SETUP;
          end
        end
        ST_SETUP: begin
          ap_nxt    = ap_c;
          aq_nxt    = aq_c;
          op_nxt    = 2'(p_r - apn[DOF_W-1:0]);
          oq_nxt    = 2'(q_r - aqn[DOF_W-1:0]);
          ok_nxt    = ({1'b0, p_r} < ndof) && ({1'b0, q_r} < ndof);
          phase_nxt = (ap_c != aq_c);
          i0_nxt = '0;  i1_nxt = '0;  i2_nxt = '0;  i3_nxt = '0;  ar_nxt = '0;
          state_nxt = ST_HLD;
        end
        ST_HLD: begin
          if (ok_r) begin
            acc_nxt   = {{(ACC_W-VAL_W){h_rdata[VAL_W-1]}}, h_rdata};
            state_nxt = ST_ADDR;
          end else begin
            acc_nxt   = '0;
            state_nxt = ST_IDLE;
            done_nxt  = 1'b1;
          end
        end
        ST_ADDR: begin
          if (!phase_r) begin
            c1_nxt = chi(op_r, oq_r, i0_r, dipole);
            c2_nxt = chi(i1_r, i2_r, i3_r, dipole);
          end else begin
            c1_nxt = chi(i2_r, oq_r, i3_r, dipole);
            c2_nxt = chi(op_r, i0_r, i1_r, dipole);
          end
          state_nxt = ST_CC;
        end
        ST_CC: begin
          state_nxt = ST_VD;
        end
        ST_VD: begin
          cc_nxt    = prod_sat;
          state_nxt = ST_TERM;
        end
        ST_TERM: begin
          state_nxt = ST_ACC;
        end
        ST_ACC: begin
          if (!phase_r) begin
            acc_nxt = acc_r + (term64 <<< 1);
          end else begin
            acc_nxt = acc_r - term64;
          end
          i3_nxt = w3 ? 2'd0 : 2'(i3_r + 2'd1);
          if (w3) begin
            i2_nxt = w2 ? 2'd0 : 2'(i2_r + 2'd1);
          end
          if (w2) begin
            i1_nxt = w1 ? 2'd0 : 2'(i1_r + 2'd1);
          end
          if (w1 && !phase_r) begin
            ar_nxt = wa ? '0 : 6'(ar_r + 6'd1);
          end
          if (wa) begin
            i0_nxt = w0 ? 2'd0 : 2'(i0_r + 2'd1);
          end
          if (w0 && !phase_r) begin
            phase_nxt = 1'b1;
            state_nxt = ST_ADDR;
          end else if (w0) begin
            state_nxt = ST_IDLE;
            done_nxt  = 1'b1;
          end else begin
            state_nxt = ST_ADDR;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
      ov_r    <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      ov_r    <= ov_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;  q_r <= q_nxt;  n_r <= n_nxt;  atoms_r <= atoms_nxt;
    ap_r <= ap_nxt;  aq_r <= aq_nxt;  op_r <= op_nxt;  oq_r <= oq_nxt;  ok_r <= ok_nxt;
    i0_r <= i0_nxt;  i1_r <= i1_nxt;  i2_r <= i2_nxt;  i3_r <= i3_nxt;  ar_r <= ar_nxt;
    c1_r <= c1_nxt;  c2_r <= c2_nxt;  cc_r <= cc_nxt;  acc_r <= acc_nxt;
    orow_r <= orow_nxt;  ocol_r <= ocol_nxt;  oval_r <= oval_nxt;
  end

`ifndef NO_ASSERTIONS
  a_start_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (start && state_r == ST_IDLE && !done_r) |=> (state_r == ST_SETUP))
    else $error("read transaction did not enter setup");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(done_r))
    else $error("result loaded without a finished read");
  a_mac_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADDR) |-> ok_r)
    else $error("term walk started for an element outside the matrix");
  a_ctr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADDR) |-> (i0_r <= nm1 && i1_r <= nm1 && i2_r <= nm1 && i3_r <= nm1))
    else $error("orbital counter beyond orbital count");
`endif

endmodule

### hdl/fock_matrix_element_build_unit.sv
// Fock matrix element build unit: loads are accepted back to back while no read is in progress.
// A read walks n^4*(atoms+1) terms when p and q share an atom, n^4 otherwise, and none
// outside the matrix (n orbitals per atom); each term steps through ADDR, CC, VD, TERM, ACC.
// All terms pass one shared multiplier; the input stalls for the whole read.
// Synchronous active-low reset: atom count 1, orbital count 4, dipole strength 0.
// Stores are not cleared by reset.
module fock_matrix_element_build_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_kind,
  input  logic [fmb_pkg::DOF_W-1:0]          in_row_index,
  input  logic [fmb_pkg::DOF_W-1:0]          in_col_index,
  input  logic signed [fmb_pkg::VAL_W-1:0]   in_element_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fmb_pkg::DOF_W-1:0]          out_element_row,
  output logic [fmb_pkg::DOF_W-1:0]          out_element_col,
  output logic signed [fmb_pkg::VAL_W-1:0]   out_fock_value,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [31:0]                        cfg_data
);
  import fmb_pkg::*;

  logic [6:0]              atom_count_r;
  logic [2:0]              orbitals_r;
  logic signed [VAL_W-1:0] dipole_r;

  logic                    busy;
  logic                    acc_in;
  logic                    start;
  logic [ADDR_W-1:0]       waddr;
  rd_t                     rd;
  logic signed [VAL_W-1:0] h_rdata, v_rdata, d_rdata;
  logic signed [VAL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  assign in_stall  = busy;
  assign cfg_ready = 1'b1;
  assign acc_in    = in_valid && !in_stall;
  assign start     = acc_in && (in_kind == KIND_READ);
  assign waddr     = {in_row_index, in_col_index};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atom_count_r <= 7'd1;
      orbitals_r   <= 3'd4;
      dipole_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ATOM_COUNT: atom_count_r <= cfg_data[6:0];
        CFG_ORBITALS:   orbitals_r   <= cfg_data[2:0];
        CFG_DIPOLE:     dipole_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fmb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DOF * MAX_DOF)) u_h_ram (
    .clk   (clk),
    .we    (acc_in && in_kind == KIND_LOAD_H),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (rd.h_addr),
    .rdata (h_rdata)
  );

  fmb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DOF * MAX_DOF)) u_v_ram (
    .clk   (clk),
    .we    (acc_in && in_kind == KIND_LOAD_V),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (rd.v_addr),
    .rdata (v_rdata)
  );

  fmb_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DOF * MAX_DOF)) u_d_ram (
    .clk   (clk),
    .we    (acc_in && in_kind == KIND_LOAD_D),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (rd.d_addr),
    .rdata (d_rdata)
  );

  fmb_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod)
  );

  fmb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_row     (in_row_index),
    .in_col     (in_col_index),
    .orbitals   (orbitals_r),
    .atom_count (atom_count_r),
    .dipole     (dipole_r),
    .h_rdata    (h_rdata),
    .v_rdata    (v_rdata),
    .d_rdata    (d_rdata),
    .prod       (prod),
    .out_stall  (out_stall),
    .busy       (busy),
    .rd         (rd),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .out_valid  (out_valid),
    .out_row    (out_element_row),
    .out_col    (out_element_col),
    .out_value  (out_fock_value)
  );

endmodule

### dv/fock_matrix_element_build_unit_tb.sv
// Testbench for the Fock matrix element build unit: loads H, V and D entries, reads
// Fock elements under several register settings, and checks each returned element
// against a behavioral predictor held here. Depends on fmb_pkg and the unit's RTL.
`timescale 1ns / 1ps

module fock_matrix_element_build_unit_tb;
  import fmb_pkg::*;

  localparam int IDLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic [DOF_W-1:0] row;
    logic [DOF_W-1:0] col;
    logic signed [VAL_W-1:0] fock;
  } fock_elem_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = KIND_LOAD_H;
  logic [DOF_W-1:0] in_row_index = '0;
  logic [DOF_W-1:0] in_col_index = '0;
  logic signed [VAL_W-1:0] in_element_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DOF_W-1:0] out_element_row;
  logic [DOF_W-1:0] out_element_col;
  logic signed [VAL_W-1:0] out_fock_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_ATOM_COUNT;
  logic [31:0] cfg_data = '0;

  fock_matrix_element_build_unit dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic signed [VAL_W-1:0] ham_m [MAX_DOF][MAX_DOF];
  logic signed [VAL_W-1:0] int_m [MAX_DOF][MAX_DOF];
  logic signed [VAL_W-1:0] den_m [MAX_DOF][MAX_DOF];
  bit ham_wr [MAX_DOF][MAX_DOF];
  bit int_wr [MAX_DOF][MAX_DOF];
  bit den_wr [MAX_DOF][MAX_DOF];
  logic [6:0] atom_cfg = 7'd1;
  logic [2:0] orb_cfg = 3'd4;
  logic signed [31:0] dip_cfg = '0;

  fock_elem_t fock_pending[$];
  int n_loads, n_reads, n_cfg, n_checked, n_mismatch, n_settings;
  int idle_cycles;
  bit send_quiet, recv_quiet;
  int stall_left;

  function automatic int orb_n();
    if (orb_cfg == 0) return 1;
    if (orb_cfg > 4) return 4;
    return orb_cfg;
  endfunction

  function automatic int dim_n();
    int n, atoms;
    n = orb_n();
    atoms = (atom_cfg > MAX_DOF / n) ? MAX_DOF / n : atom_cfg;
    return atoms * n;
  endfunction

  function automatic longint sat_q(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint coupling(int a, int b, int c);
    bit c_p;
    c_p = (c > 0 && c <= 3);
    if (a == b && c == 0) return longint'(Q_ONE);
    if (a == c && c_p && b == 0) return longint'(dip_cfg);
    if (b == c && c_p && a == 0) return longint'(dip_cfg);
    return 0;
  endfunction

  function automatic longint exchange_term(longint c1, longint c2, int t, int u, int r, int s);
    longint cc, vd;
    cc = sat_q(qmul(c1, c2));
    vd = sat_q(qmul(longint'(int_m[t][u]), longint'(den_m[r][s])));
    return qmul(cc, vd);
  endfunction

  function automatic logic signed [VAL_W-1:0] predict_fock(int p, int q);
    int n, ndof, ap, op, aq, oq, t, ar, orr;
    longint acc, c1, c2;
    n = orb_n();
    ndof = dim_n();
    if (p >= ndof || q >= ndof) return '0;
    ap = p / n; op = p % n; aq = q / n; oq = q % n;
    acc = longint'(ham_m[p][q]);
    if (ap == aq) begin
      for (int a = 0; a < n; a++) begin
        t = ap * n + a;
        c1 = coupling(op, oq, a);
        for (int r = 0; r < ndof; r++) begin
          ar = r / n; orr = r % n;
          for (int s = 0; s < n; s++)
            for (int u = 0; u < n; u++)
              acc += 2 * exchange_term(c1, coupling(orr, s, u), t, ar * n + u, r, ar * n + s);
        end
      end
    end
    for (int a = 0; a < n; a++)
      for (int b = 0; b < n; b++) begin
        c2 = coupling(op, a, b);
        for (int o1 = 0; o1 < n; o1++)
          for (int o2 = 0; o2 < n; o2++)
            acc -= exchange_term(coupling(o1, oq, o2), c2, aq * n + o2, ap * n + b,
                                 aq * n + o1, ap * n + a);
      end
    return VAL_W'(sat_q(acc));
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  // transaction on the input channel; predictor advances at acceptance
  task automatic send_item(logic [1:0] kind, int p, int q, logic signed [VAL_W-1:0] v);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_row_index <= p[DOF_W-1:0];
    in_col_index <= q[DOF_W-1:0];
    in_element_value <= v;
    do @(posedge clk); while (in_stall);
    case (kind)
      KIND_LOAD_H: begin ham_m[p][q] = v; ham_wr[p][q] = 1; n_loads++; end
      KIND_LOAD_V: begin int_m[p][q] = v; int_wr[p][q] = 1; n_loads++; end
      KIND_LOAD_D: begin den_m[p][q] = v; den_wr[p][q] = 1; n_loads++; end
      default: begin
        fock_pending.push_back('{p[DOF_W-1:0], q[DOF_W-1:0], predict_fock(p, q)});
        n_reads++;
      end
    endcase
  endtask

  task automatic fill_if_unwritten(logic [1:0] kind, int r, int c);
    bit wr;
    wr = (kind == KIND_LOAD_H) ? ham_wr[r][c] : (kind == KIND_LOAD_V) ? int_wr[r][c]
                                                                     : den_wr[r][c];
    if (!wr) send_item(kind, r, c, rand_value());
  endtask

  // load every entry a read of (p,q) touches that has never been written
  task automatic read_element(int p, int q);
    int n, ndof, ap, aq, ar;
    n = orb_n();
    ndof = dim_n();
    if (p < ndof && q < ndof) begin
      ap = p / n; aq = q / n;
      fill_if_unwritten(KIND_LOAD_H, p, q);
      if (ap == aq)
        for (int a = 0; a < n; a++)
          for (int r = 0; r < ndof; r++) begin
            ar = r / n;
            for (int s = 0; s < n; s++) begin
              fill_if_unwritten(KIND_LOAD_V, ap * n + a, ar * n + s);
              fill_if_unwritten(KIND_LOAD_D, r, ar * n + s);
            end
          end
      for (int a = 0; a < n; a++)
        for (int b = 0; b < n; b++) begin
          fill_if_unwritten(KIND_LOAD_V, aq * n + a, ap * n + b);
          fill_if_unwritten(KIND_LOAD_D, aq * n + a, ap * n + b);
        end
    end
    send_item(KIND_READ, p, q, rand_value());
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (fock_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ATOM_COUNT: atom_cfg = data[6:0];
      CFG_ORBITALS:   orb_cfg = data[2:0];
      CFG_DIPOLE:     dip_cfg = data;
      default: ;
    endcase
    n_cfg++;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic configure(int atoms, int orbs, logic [31:0] dip);
    drain();
    write_reg(CFG_ATOM_COUNT, atoms);
    write_reg(CFG_ORBITALS, orbs);
    write_reg(CFG_DIPOLE, dip);
    n_settings++;
  endtask

  task automatic random_traffic(int count, int read_pct);
    int ndof, n, p, q;
    for (int i = 0; i < count; i++) begin
      ndof = dim_n();
      n = orb_n();
      if (i % 16 == 0) begin
        send_quiet = $urandom_range(0, 2) == 0;
        recv_quiet = $urandom_range(0, 2) == 0;
      end
      if ($urandom_range(0, 99) >= read_pct) begin
        send_item(2'($urandom_range(0, 2)), $urandom_range(0, MAX_DOF - 1),
                  $urandom_range(0, MAX_DOF - 1), rand_value());
      end else if (ndof == 0 || $urandom_range(0, 4) == 0) begin
        read_element($urandom_range(0, MAX_DOF - 1), $urandom_range(0, MAX_DOF - 1));
      end else begin
        p = $urandom_range(0, ndof - 1);
        q = $urandom_range(0, 1) ? (p / n) * n + $urandom_range(0, n - 1)
                                 : $urandom_range(0, ndof - 1);
        read_element(p, q);
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_item(KIND_LOAD_H, 0, 0, 32'sh7FFF_FFFF);
    send_item(KIND_LOAD_H, 3, 3, 32'sh8000_0000);
    send_item(KIND_LOAD_H, 63, 63, 32'sh0000_0001);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        send_item(KIND_LOAD_V, r, c, (r == c) ? 32'sh7FFF_FFFF : 32'sh0010_0000);
        send_item(KIND_LOAD_D, r, c, (r == c) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
      end
    read_element(0, 0);
    read_element(3, 3);
    read_element(0, 3);
    read_element(4, 0);
    read_element(63, 63);
    read_element(2, 63);
  endtask

  task automatic test_two_atoms_half_dipole();
    configure(2, 2, 32'sh0008_0000);
    read_element(0, 1);
    read_element(1, 2);
    random_traffic(6, 50);
  endtask

  task automatic test_three_orbitals_max_dipole();
    configure(2, 3, 32'h7FFF_FFFF);
    read_element(0, 2);
    read_element(4, 4);
    random_traffic(4, 50);
  endtask

  task automatic test_single_orbital_full_width();
    configure(64, 1, 32'h8000_0000);
    read_element(63, 0);
    read_element(0, 63);
    read_element(40, 5);
  endtask

  task automatic test_degenerate_sizes();
    configure(0, 0, $urandom);
    read_element(0, 0);
    read_element(63, 63);
    configure(5, 2, $urandom);
    random_traffic(3, 50);
  endtask

  task automatic test_oversized_counts();
    configure(127, 7, 32'sh0004_0000);
    read_element(63, 0);
    configure(100, 5, $urandom);
    read_element(62, 1);
    configure(127, 6, 32'sh0000_0000);
    read_element(61, 2);
  endtask

  task automatic test_drain_pause();
    configure(2, 2, 32'sh0010_0000);
    random_traffic(6, 60);
    drain();
    random_traffic(6, 60);
  endtask

  task automatic test_random_mix();
    configure($urandom_range(1, 2), $urandom_range(1, 2), $urandom);
    random_traffic(8, 45);
    configure(1, 4, 32'h0);
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    fock_elem_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (fock_pending.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("ERROR: unexpected result row %0d col %0d value %0d",
                   out_element_row, out_element_col, out_fock_value);
      end else begin
        want = fock_pending.pop_front();
        n_checked++;
        if (out_element_row !== want.row || out_element_col !== want.col ||
            out_fock_value !== want.fock) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("ERROR: expected (%0d,%0d)=%0d got (%0d,%0d)=%0d", want.row, want.col,
                     want.fock, out_element_row, out_element_col, out_fock_value);
        end
      end
      stall_left = recv_quiet ? 0 : $urandom_range(0, 10);
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_two_atoms_half_dipole();
    test_three_orbitals_max_dipole();
    test_single_orbital_full_width();
    test_degenerate_sizes();
    test_oversized_counts();
    test_drain_pause();
    test_random_mix();
    drain();
    repeat (50) @(posedge clk);
    $display("Ran %0d loads and %0d Fock reads over %0d register settings (%0d writes).",
             n_loads, n_reads, n_settings + 1, n_cfg);
    $display("Checked %0d returned elements, %0d mismatches.", n_checked, n_mismatch);
    if (n_mismatch == 0 && fock_pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
hdl/fmb_pkg.sv
hdl/fmb_ram.sv
hdl/fmb_mul.sv
hdl/fmb_ctrl.sv
hdl/fock_matrix_element_build_unit.sv
dv/fock_matrix_element_build_unit_tb.sv
